@@ rtl/edge_aware_3x3_mean_filter_defines.svh @@
// ---------------------------------------------------------------------------
// edge_aware_3x3_mean_filter_defines.svh
// assertion macros used by the checker file of the mean filter
// ---------------------------------------------------------------------------
`ifndef EDGE_AWARE_3X3_MEAN_FILTER_DEFINES_SVH
`define EDGE_AWARE_3X3_MEAN_FILTER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define EAMF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define EAMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/eamf_pkg.sv @@
// ---------------------------------------------------------------------------
// eamf_pkg
// types, sizes and arithmetic helpers of the 3x3 mean filter
// ---------------------------------------------------------------------------
package eamf_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PIX_BITS      = 8;
  localparam int COL_BITS      = 10;
  localparam int ROW_BITS      = 12;
  localparam int WREG_BITS     = 11;
  localparam int HREG_BITS     = 13;
  localparam int SUM_BITS      = 12;
  localparam int CNT_BITS      = 4;
  localparam int LANES         = 4;
  localparam int LANE_IDX_BITS = 3;
  localparam int QDEPTH        = 8;
  localparam int QCNT_BITS     = 4;
  localparam int OCC_BITS      = 5;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // reciprocal constants for division by 3 and by 9 (exact for sums seen here)
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_BITS   = SUM_BITS + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP3 = RECIP_SHIFT'(21846);
  localparam logic [RECIP_SHIFT-1:0] RECIP9 = RECIP_SHIFT'(7282);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [8:0][PIX_BITS-1:0] win_t;

  typedef struct packed {
    logic                valid;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] cnt;
    logic                done;
  } lane_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [PIX_BITS-1:0] smoothed;
    logic                done;
  } res_t;

  function automatic logic [WREG_BITS-1:0] eff_width(input logic [WREG_BITS-1:0] w);
    logic [WREG_BITS-1:0] e;
    if (w == '0) begin
      e = WREG_BITS'(1);
    end else if (w > WREG_BITS'(MAX_WIDTH)) begin
      e = WREG_BITS'(MAX_WIDTH);
    end else begin
      e = w;
    end
    return e;
  endfunction

  function automatic logic [HREG_BITS-1:0] eff_height(input logic [HREG_BITS-1:0] h);
    logic [HREG_BITS-1:0] e;
    if (h == '0) begin
      e = HREG_BITS'(1);
    end else if (h > HREG_BITS'(MAX_HEIGHT)) begin
      e = HREG_BITS'(MAX_HEIGHT);
    end else begin
      e = h;
    end
    return e;
  endfunction

  // sum over the window cells selected by row mask and column mask
  function automatic logic [SUM_BITS-1:0] win_sum(input win_t win, input logic [2:0] rm,
                                                  input logic [2:0] cm);
    logic [SUM_BITS-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rm[i] && cm[j]) begin
          acc = acc + SUM_BITS'(win[i*3+j]);
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [CNT_BITS-1:0] win_cnt(input logic [2:0] rm, input logic [2:0] cm);
    logic [CNT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rm[i] && cm[j]) begin
          n = n + CNT_BITS'(1);
        end
      end
    end
    return n;
  endfunction

  // floor(sum / cnt) for cnt in 1, 2, 3, 4, 6, 9
  function automatic logic [PIX_BITS-1:0] mean_of(input logic [SUM_BITS-1:0] sum,
                                                  input logic [CNT_BITS-1:0] cnt);
    logic [PROD_BITS-1:0] prod;
    logic [SUM_BITS-1:0]  q;
    prod = '0;
    q    = sum;
    case (cnt)
      CNT_BITS'(2): q = {1'b0, sum[SUM_BITS-1:1]};
      CNT_BITS'(4): q = {2'b0, sum[SUM_BITS-1:2]};
      CNT_BITS'(3): begin
        prod = PROD_BITS'(sum) * PROD_BITS'(RECIP3);
        q    = prod[PROD_BITS-1:RECIP_SHIFT];
      end
      CNT_BITS'(6): begin
        prod = PROD_BITS'(sum[SUM_BITS-1:1]) * PROD_BITS'(RECIP3);
        q    = prod[PROD_BITS-1:RECIP_SHIFT];
      end
      CNT_BITS'(9): begin
        prod = PROD_BITS'(sum) * PROD_BITS'(RECIP9);
        q    = prod[PROD_BITS-1:RECIP_SHIFT];
      end
      default: q = sum;
    endcase
    return q[PIX_BITS-1:0];
  endfunction

endpackage

@@ rtl/eamf_ifs.sv @@
// ---------------------------------------------------------------------------
// eamf_ifs
// valid/ready channels of the mean filter: pixel input and result output
// ---------------------------------------------------------------------------
interface eamf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [eamf_pkg::PIX_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface eamf_res_if;
  logic                          valid;
  logic                          ready;
  logic [eamf_pkg::ROW_BITS-1:0] out_row;
  logic [eamf_pkg::COL_BITS-1:0] out_col;
  logic [eamf_pkg::PIX_BITS-1:0] smoothed;
  logic                          image_done;

  modport source (output valid, output out_row, output out_col, output smoothed,
                  output image_done, input ready);
  modport sink (input valid, input out_row, input out_col, input smoothed,
                input image_done, output ready);
endinterface

@@ rtl/eamf_ram.sv @@
// ---------------------------------------------------------------------------
// eamf_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module eamf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/edge_aware_3x3_mean_filter.sv @@
// ---------------------------------------------------------------------------
// edge_aware_3x3_mean_filter
// 3x3 box mean over a raster pixel stream with border normalization
// ---------------------------------------------------------------------------
// in_pix carries one 8-bit pixel per word in raster order; out_res carries
// (out_row, out_col, smoothed, image_done) words, image_done marking the last
// result of an image. image_width / image_height are written over the apb
// port at 0x0 / 0x4 while the block is idle; a write restarts the image.
// A pixel is taken every cycle that in_pix.ready is high: it reads the two
// line stores (one 16-bit ram, one read and one write port) in its accept
// cycle, updates the window and writes back in the next cycle, and its
// results pass the lane registers into the output queue. An inner result is
// released by the pixel one row and one column later. The output queue holds
// eight results and drains one per cycle while out_res.ready is high, so the
// last row (two results per pixel) and row ends (two results) pace the input
// through in_pix.ready; elsewhere the input runs at one pixel per cycle.
// A stalled receiver fills the queue, then input ready drops; nothing is lost.
// Reset empties the pipeline and queue and sets the geometry to 1x1. The
// line stores are not cleared: entries read before written are masked out.
// ---------------------------------------------------------------------------
module edge_aware_3x3_mean_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  eamf_pix_if.sink                               in_pix,
  eamf_res_if.source                             out_res,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [eamf_pkg::APB_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [eamf_pkg::APB_DATA_BITS-1:0]     cfg_pwdata,
  output logic [eamf_pkg::APB_DATA_BITS-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int LS_BITS = 2 * eamf_pkg::PIX_BITS;

  // configuration
  logic [eamf_pkg::WREG_BITS-1:0] width_r;
  logic [eamf_pkg::HREG_BITS-1:0] height_r;
  logic [eamf_pkg::WREG_BITS-1:0] eff_w;
  logic [eamf_pkg::HREG_BITS-1:0] eff_h;
  logic                           cfg_we;
  eamf_pkg::reg_idx_t             cfg_idx;

  // input position counters
  logic [eamf_pkg::COL_BITS-1:0] col_r;
  logic [eamf_pkg::ROW_BITS-1:0] row_r;
  logic                          in_acc;
  logic                          last_col;
  logic                          last_row;

  // stage 1: line store data returns, window update, write back
  logic                          s1_v_r;
  logic [eamf_pkg::COL_BITS-1:0] s1_col_r;
  logic [eamf_pkg::ROW_BITS-1:0] s1_row_r;
  logic                          s1_last_col_r;
  logic                          s1_last_row_r;
  logic [eamf_pkg::PIX_BITS-1:0] s1_pix_r;
  logic                          fwd_v_r;
  logic [LS_BITS-1:0]            fwd_data_r;
  logic [LS_BITS-1:0]            ls_rdata;
  logic [LS_BITS-1:0]            ls_wdata;
  logic [eamf_pkg::PIX_BITS-1:0] up_rd;
  logic [eamf_pkg::PIX_BITS-1:0] mid_rd;
  eamf_pkg::win_t                win_r;
  eamf_pkg::win_t                win_nxt;
  eamf_pkg::lane_t [eamf_pkg::LANES-1:0] lane_nxt;
  logic [eamf_pkg::LANE_IDX_BITS-1:0]    n1;

  // stage 2: divide and push into the output queue
  eamf_pkg::lane_t [eamf_pkg::LANES-1:0] lane_r;
  logic [eamf_pkg::LANE_IDX_BITS-1:0]    n2;

  // output queue, head at slot 0
  eamf_pkg::res_t [eamf_pkg::QDEPTH-1:0] q_r;
  eamf_pkg::res_t [eamf_pkg::QDEPTH-1:0] q_nxt;
  logic [eamf_pkg::QCNT_BITS-1:0]        q_cnt_r;
  logic [eamf_pkg::QCNT_BITS-1:0]        q_cnt_nxt;
  logic                                  pop;
  logic [eamf_pkg::OCC_BITS-1:0]         occ;

  // ---------------------------------------------------------------- config
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = eamf_pkg::reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    case (cfg_idx)
      eamf_pkg::REG_IMAGE_WIDTH:
        cfg_prdata = eamf_pkg::APB_DATA_BITS'(width_r);
      eamf_pkg::REG_IMAGE_HEIGHT:
        cfg_prdata = eamf_pkg::APB_DATA_BITS'(height_r);
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= eamf_pkg::WREG_BITS'(1);
      height_r <= eamf_pkg::HREG_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        eamf_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[eamf_pkg::WREG_BITS-1:0];
        eamf_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[eamf_pkg::HREG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = eamf_pkg::eff_width(width_r);
  assign eff_h = eamf_pkg::eff_height(height_r);

  // -------------------------------------------------------------- stage 0
  assign in_acc   = in_pix.valid & in_pix.ready;
  assign last_col = ({1'b0, col_r} == (eff_w - eamf_pkg::WREG_BITS'(1)));
  assign last_row = ({1'b0, row_r} == (eff_h - eamf_pkg::HREG_BITS'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : eamf_pkg::ROW_BITS'(row_r + 1'b1);
      end else begin
        col_r <= eamf_pkg::COL_BITS'(col_r + 1'b1);
      end
    end
  end

  // upper store in the high byte, middle store in the low byte
  eamf_ram #(
    .WIDTH (LS_BITS),
    .DEPTH (eamf_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (ls_wdata),
    .raddr (col_r),
    .rdata (ls_rdata)
  );

  // -------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_acc;
      // same column read while the previous word writes it (one-pixel rows)
      fwd_v_r <= in_acc & s1_v_r & (col_r == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      s1_pix_r      <= in_pix.pixel;
    end
    fwd_data_r <= ls_wdata;
  end

  assign up_rd    = fwd_v_r ? fwd_data_r[LS_BITS-1:eamf_pkg::PIX_BITS]
                            : ls_rdata[LS_BITS-1:eamf_pkg::PIX_BITS];
  assign mid_rd   = fwd_v_r ? fwd_data_r[eamf_pkg::PIX_BITS-1:0]
                            : ls_rdata[eamf_pkg::PIX_BITS-1:0];
  assign ls_wdata = {mid_rd, s1_pix_r};

  always_comb begin
    win_nxt = win_r;
    if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_nxt[k*3+0] = win_r[k*3+1];
        win_nxt[k*3+1] = win_r[k*3+2];
      end
      win_nxt[2] = up_rd;
      win_nxt[5] = mid_rd;
      win_nxt[8] = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  // lanes in release order: row above (inner, right edge), then last row
  always_comb begin
    logic       r_ge1;
    logic       r_ge2;
    logic       c_ge1;
    logic       c_ge2;
    logic [2:0] rm_prev;
    logic [2:0] rm_last;
    logic [2:0] cm_mid;
    logic [2:0] cm_edge;
    r_ge1   = (s1_row_r != '0);
    r_ge2   = (s1_row_r > eamf_pkg::ROW_BITS'(1));
    c_ge1   = (s1_col_r != '0);
    c_ge2   = (s1_col_r > eamf_pkg::COL_BITS'(1));
    rm_prev = {1'b1, 1'b1, r_ge2};
    rm_last = {1'b1, r_ge1, 1'b0};
    cm_mid  = {1'b1, 1'b1, c_ge2};
    cm_edge = {1'b1, c_ge1, 1'b0};

    lane_nxt[0].valid = s1_v_r & r_ge1 & c_ge1;
    lane_nxt[0].row   = eamf_pkg::ROW_BITS'(s1_row_r - 1'b1);
    lane_nxt[0].col   = eamf_pkg::COL_BITS'(s1_col_r - 1'b1);
    lane_nxt[0].sum   = eamf_pkg::win_sum(win_nxt, rm_prev, cm_mid);
    lane_nxt[0].cnt   = eamf_pkg::win_cnt(rm_prev, cm_mid);
    lane_nxt[0].done  = 1'b0;

    lane_nxt[1].valid = s1_v_r & r_ge1 & s1_last_col_r;
    lane_nxt[1].row   = eamf_pkg::ROW_BITS'(s1_row_r - 1'b1);
    lane_nxt[1].col   = s1_col_r;
    lane_nxt[1].sum   = eamf_pkg::win_sum(win_nxt, rm_prev, cm_edge);
    lane_nxt[1].cnt   = eamf_pkg::win_cnt(rm_prev, cm_edge);
    lane_nxt[1].done  = 1'b0;

    lane_nxt[2].valid = s1_v_r & s1_last_row_r & c_ge1;
    lane_nxt[2].row   = s1_row_r;
    lane_nxt[2].col   = eamf_pkg::COL_BITS'(s1_col_r - 1'b1);
    lane_nxt[2].sum   = eamf_pkg::win_sum(win_nxt, rm_last, cm_mid);
    lane_nxt[2].cnt   = eamf_pkg::win_cnt(rm_last, cm_mid);
    lane_nxt[2].done  = 1'b0;

    lane_nxt[3].valid = s1_v_r & s1_last_row_r & s1_last_col_r;
    lane_nxt[3].row   = s1_row_r;
    lane_nxt[3].col   = s1_col_r;
    lane_nxt[3].sum   = eamf_pkg::win_sum(win_nxt, rm_last, cm_edge);
    lane_nxt[3].cnt   = eamf_pkg::win_cnt(rm_last, cm_edge);
    lane_nxt[3].done  = 1'b1;
  end

  always_comb begin
    n1 = '0;
    n2 = '0;
    for (int j = 0; j < eamf_pkg::LANES; j++) begin
      n1 = n1 + eamf_pkg::LANE_IDX_BITS'(lane_nxt[j].valid);
      n2 = n2 + eamf_pkg::LANE_IDX_BITS'(lane_r[j].valid);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < eamf_pkg::LANES; j++) begin
      if (!rst_n) begin
        lane_r[j].valid <= 1'b0;
      end else begin
        lane_r[j].valid <= lane_nxt[j].valid;
      end
      lane_r[j].row  <= lane_nxt[j].row;
      lane_r[j].col  <= lane_nxt[j].col;
      lane_r[j].sum  <= lane_nxt[j].sum;
      lane_r[j].cnt  <= lane_nxt[j].cnt;
      lane_r[j].done <= lane_nxt[j].done;
    end
  end

  // -------------------------------------------------------- output queue
  assign pop = out_res.valid & out_res.ready;

  always_comb begin
    logic [eamf_pkg::QCNT_BITS-1:0]     base;
    logic [eamf_pkg::LANE_IDX_BITS-1:0] pfx;
    eamf_pkg::res_t                     res;
    base = q_cnt_r - eamf_pkg::QCNT_BITS'(pop);
    for (int i = 0; i < eamf_pkg::QDEPTH; i++) begin
      if (pop && (i < eamf_pkg::QDEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % eamf_pkg::QDEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    pfx = '0;
    for (int j = 0; j < eamf_pkg::LANES; j++) begin
      res.row      = lane_r[j].row;
      res.col      = lane_r[j].col;
      res.smoothed = eamf_pkg::mean_of(lane_r[j].sum, lane_r[j].cnt);
      res.done     = lane_r[j].done;
      for (int i = 0; i < eamf_pkg::QDEPTH; i++) begin
        if (lane_r[j].valid &&
            ((base + eamf_pkg::QCNT_BITS'(pfx)) == eamf_pkg::QCNT_BITS'(i))) begin
          q_nxt[i] = res;
        end
      end
      pfx = pfx + eamf_pkg::LANE_IDX_BITS'(lane_r[j].valid);
    end
    q_cnt_nxt = base + eamf_pkg::QCNT_BITS'(n2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // room for every result already in flight plus a full word's worth
  assign occ = eamf_pkg::OCC_BITS'(q_cnt_r) + eamf_pkg::OCC_BITS'(n1)
             + eamf_pkg::OCC_BITS'(n2);
  assign in_pix.ready = (occ <= eamf_pkg::OCC_BITS'(eamf_pkg::QDEPTH - eamf_pkg::LANES));

  assign out_res.valid      = (q_cnt_r != '0);
  assign out_res.out_row    = q_r[0].row;
  assign out_res.out_col    = q_r[0].col;
  assign out_res.smoothed   = q_r[0].smoothed;
  assign out_res.image_done = q_r[0].done;

endmodule

@@ rtl/eamf_chk.sv @@
// ---------------------------------------------------------------------------
// eamf_chk
// port-level checks of the mean filter, bound to the top level
// ---------------------------------------------------------------------------
`include "edge_aware_3x3_mean_filter_defines.svh"

module eamf_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [eamf_pkg::ROW_BITS-1:0]      out_row,
  input logic [eamf_pkg::COL_BITS-1:0]      out_col,
  input logic [eamf_pkg::PIX_BITS-1:0]      smoothed,
  input logic                               image_done,
  input logic                               cfg_psel,
  input logic                               cfg_penable,
  input logic                               cfg_pwrite,
  input logic [eamf_pkg::APB_ADDR_BITS-1:0] cfg_paddr,
  input logic [eamf_pkg::APB_DATA_BITS-1:0] cfg_pwdata
);

  logic [eamf_pkg::WREG_BITS-1:0] w_sh_r;
  logic [eamf_pkg::HREG_BITS-1:0] h_sh_r;
  logic [eamf_pkg::WREG_BITS-1:0] ew;
  logic [eamf_pkg::HREG_BITS-1:0] eh;
  logic                           at_corner;
  logic                           in_image;
  logic [eamf_pkg::ROW_BITS+eamf_pkg::COL_BITS+eamf_pkg::PIX_BITS:0] out_word;

  // shadow of the geometry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_sh_r <= eamf_pkg::WREG_BITS'(1);
      h_sh_r <= eamf_pkg::HREG_BITS'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (eamf_pkg::reg_idx_t'(cfg_paddr[2]) == eamf_pkg::REG_IMAGE_HEIGHT) begin
        h_sh_r <= cfg_pwdata[eamf_pkg::HREG_BITS-1:0];
      end else begin
        w_sh_r <= cfg_pwdata[eamf_pkg::WREG_BITS-1:0];
      end
    end
  end

  assign ew        = eamf_pkg::eff_width(w_sh_r);
  assign eh        = eamf_pkg::eff_height(h_sh_r);
  assign at_corner = ({1'b0, out_col} == (ew - eamf_pkg::WREG_BITS'(1))) &&
                     ({1'b0, out_row} == (eh - eamf_pkg::HREG_BITS'(1)));
  assign in_image  = ({1'b0, out_col} < ew) && ({1'b0, out_row} < eh);
  assign out_word  = {out_row, out_col, smoothed, image_done};

  `EAMF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `EAMF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_word), "result word changed")
  `EAMF_ASSERT(a_empty_after_rst, $past(rst_n) || !out_valid, "result shown right after reset")
  `EAMF_ASSERT(a_done_at_corner, !(out_valid && image_done) || at_corner, "image_done off corner")
  `EAMF_ASSERT(a_pos_in_image, !out_valid || in_image, "result position outside the image")

endmodule

bind edge_aware_3x3_mean_filter eamf_chk u_eamf_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_row     (out_res.out_row),
  .out_col     (out_res.out_col),
  .smoothed    (out_res.smoothed),
  .image_done  (out_res.image_done),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata)
);
